// ----- sv/modbus_rtu_request_framer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU request framer
// Shared helpers for the concurrent checks in the framer modules.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REQUEST_FRAMER_UNIT_ASSERT_SVH
`define MODBUS_RTU_REQUEST_FRAMER_UNIT_ASSERT_SVH

// Checks that a property holds in every cycle outside reset.
`define MRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define MRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mrf_pkg.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Types, codes and the CRC-16 byte update shared by the framer modules.
// ----------------------------------------------------------------------------
package mrf_pkg;

  typedef enum logic [2:0] {
    OP_READ_COILS     = 3'd0,
    OP_READ_DISCRETE  = 3'd1,
    OP_READ_HOLDING   = 3'd2,
    OP_READ_INPUT     = 3'd3,
    OP_WRITE_COIL     = 3'd4,
    OP_WRITE_REGISTER = 3'd5,
    OP_UNKNOWN        = 3'd6
  } op_e;

  localparam logic [7:0] FC_READ_COILS     = 8'h01;
  localparam logic [7:0] FC_READ_DISCRETE  = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT     = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
  localparam logic [7:0] FC_WRITE_REGISTER = 8'h06;
  localparam logic [7:0] FC_UNKNOWN        = 8'hFF;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] COIL_ON  = 16'hFF00;

  // Byte positions within the eight-byte frame.
  localparam logic [2:0] POS_SLAVE   = 3'd0;
  localparam logic [2:0] POS_CODE    = 3'd1;
  localparam logic [2:0] POS_ADDR_HI = 3'd2;
  localparam logic [2:0] POS_ADDR_LO = 3'd3;
  localparam logic [2:0] POS_WORD_HI = 3'd4;
  localparam logic [2:0] POS_WORD_LO = 3'd5;
  localparam logic [2:0] POS_CRC_LO  = 3'd6;
  localparam logic [2:0] POS_CRC_HI  = 3'd7;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0]  slave;
    logic [7:0]  code;
    logic [15:0] address;
    logic [15:0] word;
  } req_t;

  // One byte of the reflected Modbus CRC-16, bit by bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/mrf_front.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU framer front end
// Accepts requests, maps the operation to a function code and data word.
// ----------------------------------------------------------------------------
module mrf_front import mrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  slave_id_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] quantity_or_value_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output req_t        entry_o
);

  logic [7:0]  code;
  logic [15:0] word;

  always_comb begin
    word = quantity_or_value_i;
    case (op_e'(operation_i))
      OP_READ_COILS:     code = FC_READ_COILS;
      OP_READ_DISCRETE:  code = FC_READ_DISCRETE;
      OP_READ_HOLDING:   code = FC_READ_HOLDING;
      OP_READ_INPUT:     code = FC_READ_INPUT;
      OP_WRITE_COIL: begin
        code = FC_WRITE_COIL;
        word = (quantity_or_value_i != 16'h0000) ? COIL_ON : 16'h0000;
      end
      OP_WRITE_REGISTER: code = FC_WRITE_REGISTER;
      default:           code = FC_UNKNOWN;
    endcase
  end

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;
  assign entry_o    = '{slave: slave_id_i, code: code, address: start_address_i, word: word};

  // The clock and reset only serve the checks below.
  `include "modbus_rtu_request_framer_unit_assert.svh"

  `MRF_ASSERT(a_push_not_full, !(push_o && queue_full_i), "push into a full queue")
  `MRF_ASSERT(a_stall_tracks_full, in_stall_o == queue_full_i, "stall differs from full")
  `MRF_ASSERT(a_coil_word, !(push_o && entry_o.code == FC_WRITE_COIL) || entry_o.word == COIL_ON || entry_o.word == 16'h0000, "coil word not normalized")

endmodule

// ----- sv/mrf_req_queue.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU framer request queue
// Short FIFO that decouples the front end from the byte serializer.
// ----------------------------------------------------------------------------
module mrf_req_queue import mrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t entry_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output req_t entry_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] Depth   = CntW'(QUEUE_DEPTH);

  req_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign full_o  = (count_q == Depth);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  `include "modbus_rtu_request_framer_unit_assert.svh"

  `MRF_ASSERT(a_count_range, count_q <= Depth, "queue count out of range")
  `MRF_ASSERT(a_no_underflow, !(pop_i && count_q == '0), "pop from an empty queue")
  `MRF_ASSERT_NEXT(a_push_lands, push_i && !pop_i, count_q != '0, "pushed entry missing")

endmodule

// ----- sv/mrf_back.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU framer back end
// Sends the queued request as eight bytes and folds in the CRC-16 on the way.
// ----------------------------------------------------------------------------
module mrf_back import mrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  req_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);

  logic [2:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        adv, load;
  logic [7:0]  next_byte;
  logic [15:0] crc_seed;

  assign adv  = !out_valid_q || !out_stall_i;
  assign load = adv && head_valid_i;

  always_comb begin
    case (pos_q)
      POS_SLAVE:   next_byte = head_i.slave;
      POS_CODE:    next_byte = head_i.code;
      POS_ADDR_HI: next_byte = head_i.address[15:8];
      POS_ADDR_LO: next_byte = head_i.address[7:0];
      POS_WORD_HI: next_byte = head_i.word[15:8];
      POS_WORD_LO: next_byte = head_i.word[7:0];
      POS_CRC_LO:  next_byte = crc_q[7:0];
      default:     next_byte = crc_q[15:8];
    endcase
  end

  assign crc_seed = (pos_q == POS_SLAVE) ? CRC_INIT : crc_q;

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    byte_d      = byte_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (load) begin
      pos_d       = pos_q + 3'd1;
      byte_d      = next_byte;
      last_d      = (pos_q == POS_CRC_HI);
      out_valid_d = 1'b1;
      if (pos_q != POS_CRC_LO && pos_q != POS_CRC_HI) begin
        crc_d = crc_byte(crc_seed, next_byte);
      end
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_SLAVE;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign pop_o        = load && (pos_q == POS_CRC_HI);
  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;

  `include "modbus_rtu_request_framer_unit_assert.svh"

  `MRF_ASSERT(a_mid_frame_head, pos_q == POS_SLAVE || head_valid_i, "frame lost its request")
  `MRF_ASSERT(a_last_at_frame_end, !(out_valid_q && last_q) || pos_q == POS_SLAVE, "last byte mid frame")
  `MRF_ASSERT_NEXT(a_crc_hi_marks_last, load && pos_q == POS_CRC_HI, out_valid_q && last_q, "frame end not marked")

endmodule

// ----- sv/modbus_rtu_request_framer_unit.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Turns one request into an eight-byte RTU frame with a trailing CRC-16.
// ----------------------------------------------------------------------------
// Usage: a request (operation, slave id, start address, quantity or value) is
// taken on the input channel when in_valid_i is high and in_stall_o is low.
// Each request produces eight output words on the output channel: slave id,
// function code, address high and low, data word high and low, then the
// CRC-16 low and high bytes. last_byte_o marks the eighth word. A word is
// taken when out_valid_o is high and out_stall_i is low.
// With the serializer idle, a taken request is first written into the queue;
// the first byte of its frame is then loaded into the output register.
// Throughput: one byte per cycle while the receiver does not stall and a
// request is queued, set by the single output register of the byte serializer.
// A two-entry request queue sits between the front end and the serializer,
// so new requests are taken while an earlier frame is still being sent; the
// input stalls only when that queue is full.
// When the receiver stalls, the current byte holds and the serializer waits;
// the queue keeps filling until it is full.
// Reset clears the queue, the byte position and the output valid flag; the
// running CRC returns to its start value.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_unit import mrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  slave_id_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] quantity_or_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o
);

  // Classified request flowing from the front end into the queue.
  req_t push_entry;
  logic push;
  logic queue_full;

  // Queue head as seen by the serializer.
  req_t head_entry;
  logic head_valid;
  logic pop;

  mrf_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .slave_id_i         (slave_id_i),
    .start_address_i    (start_address_i),
    .quantity_or_value_i(quantity_or_value_i),
    .queue_full_i       (queue_full),
    .push_o             (push),
    .entry_o            (push_entry)
  );

  mrf_req_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (queue_full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .entry_o(head_entry)
  );

  // The serializer keeps the request at the queue head until its last byte
  // is loaded, and updates the CRC as each header byte enters the output.
  mrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_byte_o(frame_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule
